// ===== hw/rtl/ntis_pkg.sv =====
`default_nettype none

package ntis_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int NAME_BYTES_DEFAULT = 8;
   localparam int FUNC_W             = 2;
   localparam int NAME_W             = 64;
   localparam int STATUS_W           = 3;
   localparam int POS_W              = 5;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [FUNC_W-1:0] {
      CMD_CREATE = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CREATED    = 3'd0,
      ST_REMOVED    = 3'd1,
      ST_FOUND      = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_FULL       = 3'd4,
      ST_LIST_ENTRY = 3'd5,
      ST_LIST_EMPTY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_RESULT,
      S_LIST_READ,
      S_LIST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ntis_front.sv =====
`default_nettype none

module ntis_front #(
   parameter int NAME_BYTES = ntis_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ntis_pkg::FUNC_W-1:0]   req_func,
   input  logic [ntis_pkg::NAME_W-1:0]   req_file_name,
   output logic                          push,
   output ntis_pkg::cmd_type             push_cmd,
   output logic [8*NAME_BYTES-1:0]       push_key,
   input  logic                          q_full
);
   import ntis_pkg::*;

   localparam int KW = 8 * NAME_BYTES;

   logic          valid_ff, valid_in;
   cmd_type       cmd_ff, cmd_in;
   logic [KW-1:0] key_ff, key_in;
   logic          accept;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_full;
   assign push_cmd  = cmd_ff;
   assign push_key  = key_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      if (accept) begin
         valid_in = 1'b1;
         cmd_in   = cmd_type'(req_func);
         key_in   = req_file_name[KW-1:0];
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ntis_queue.sv =====
`default_nettype none

module ntis_queue #(
   parameter int W = 66
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         not_empty
);
   import ntis_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [W-1:0]     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ntis_back.sv =====
`default_nettype none

module ntis_back #(
   parameter int ENTRIES    = ntis_pkg::ENTRIES_DEFAULT,
   parameter int NAME_BYTES = ntis_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  ntis_pkg::cmd_type             q_cmd,
   input  logic [8*NAME_BYTES-1:0]       q_key,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ntis_pkg::STATUS_W-1:0] rsp_status,
   output logic [ntis_pkg::POS_W-1:0]    rsp_position,
   output logic [ntis_pkg::NAME_W-1:0]   rsp_listed_name,
   output logic                          rsp_last
);
   import ntis_pkg::*;

   localparam int KW = 8 * NAME_BYTES;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   function automatic logic [POS_W-1:0] to_pos(input logic [IW-1:0] i);
      logic [PW-1:0] p;
      p = PW'(i) + PW'(1);
      return p[POS_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;
   logic [IW-1:0]     idx_ff, idx_in;
   cmd_type           cmd_ff, cmd_in;
   logic [KW-1:0]     key_ff, key_in;
   status_type        pend_status_ff, pend_status_in;
   logic [POS_W-1:0]  pend_pos_ff, pend_pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_position_ff, rsp_position_in;
   logic [NAME_W-1:0] rsp_listed_name_ff, rsp_listed_name_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_load;

   logic [KW-1:0]     mem [ENTRIES];
   logic [KW-1:0]     rd_data_ff;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [KW-1:0]     wr_data;

   logic              can_load;
   logic              is_full;
   logic              is_empty;
   logic              issue;
   logic              match;
   logic [CW-1:0]     count_m1;
   logic [IW-1:0]     last_idx;
   logic              chk_last;
   logic              list_last;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = count_ff == CW'(ENTRIES);
   assign is_empty  = count_ff == '0;
   assign issue     = issue_ff < count_ff;
   assign match     = rd_data_ff == key_ff;
   assign count_m1  = count_ff - CW'(1);
   assign last_idx  = count_m1[IW-1:0];
   assign chk_last  = chk_idx_ff == last_idx;
   assign list_last = idx_ff == last_idx;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd)
                  CMD_CREATE: state_in = S_RESULT;
                  CMD_DELETE,
                  CMD_SEARCH: state_in = is_empty ? S_RESULT : S_SCAN;
                  CMD_LIST:   state_in = is_empty ? S_RESULT : S_LIST_READ;
                  default:    state_in = S_RESULT;
               endcase
            end
         end
         S_SCAN: begin
            if (chk_valid_ff && match) begin
               state_in = (cmd_ff == CMD_DELETE) ? S_MOVE : S_RESULT;
            end else if (chk_valid_ff && chk_last) begin
               state_in = S_RESULT;
            end
         end
         S_MOVE: state_in = S_RESULT;
         S_RESULT: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         S_LIST_READ: state_in = S_LIST_EMIT;
         S_LIST_EMIT: begin
            if (can_load) begin
               state_in = list_last ? S_IDLE : S_LIST_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in           = count_ff;
      issue_in           = issue_ff;
      chk_valid_in       = 1'b0;
      chk_idx_in         = chk_idx_ff;
      idx_in             = idx_ff;
      cmd_in             = cmd_ff;
      key_in             = key_ff;
      pend_status_in     = pend_status_ff;
      pend_pos_in        = pend_pos_ff;
      q_pop              = 1'b0;
      rd_en              = 1'b0;
      rd_addr            = idx_ff;
      wr_en              = 1'b0;
      wr_addr            = idx_ff;
      wr_data            = key_ff;
      rsp_load           = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_position_in    = rsp_position_ff;
      rsp_listed_name_in = rsp_listed_name_ff;
      rsp_last_in        = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cmd_in      = q_cmd;
               key_in      = q_key;
               pend_pos_in = '0;
               issue_in    = '0;
               idx_in      = '0;
               unique case (q_cmd)
                  CMD_CREATE: begin
                     if (is_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = count_ff[IW-1:0];
                        wr_data        = q_key;
                        count_in       = count_ff + CW'(1);
                        pend_status_in = ST_CREATED;
                     end
                  end
                  CMD_DELETE,
                  CMD_SEARCH: pend_status_in = ST_NOT_FOUND;
                  CMD_LIST:   pend_status_in = ST_LIST_EMPTY;
                  default:    pend_status_in = ST_NOT_FOUND;
               endcase
            end
         end
         S_SCAN: begin
            rd_en        = issue;
            rd_addr      = issue_ff[IW-1:0];
            issue_in     = issue ? issue_ff + CW'(1) : issue_ff;
            chk_valid_in = issue;
            chk_idx_in   = issue_ff[IW-1:0];
            if (chk_valid_ff && match) begin
               idx_in = chk_idx_ff;
               if (cmd_ff == CMD_DELETE) begin
                  rd_en   = 1'b1;
                  rd_addr = last_idx;
               end else begin
                  pend_status_in = ST_FOUND;
                  pend_pos_in    = to_pos(chk_idx_ff);
               end
            end else if (chk_valid_ff && chk_last) begin
               pend_status_in = ST_NOT_FOUND;
            end
         end
         S_MOVE: begin
            wr_en          = 1'b1;
            wr_addr        = idx_ff;
            wr_data        = rd_data_ff;
            count_in       = count_ff - CW'(1);
            pend_status_in = ST_REMOVED;
         end
         S_RESULT: begin
            if (can_load) begin
               rsp_load           = 1'b1;
               rsp_status_in      = pend_status_ff;
               rsp_position_in    = pend_pos_ff;
               rsp_listed_name_in = '0;
               rsp_last_in        = 1'b1;
            end
         end
         S_LIST_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         S_LIST_EMIT: begin
            if (can_load) begin
               rsp_load           = 1'b1;
               rsp_status_in      = ST_LIST_ENTRY;
               rsp_position_in    = to_pos(idx_ff);
               rsp_listed_name_in = NAME_W'(rd_data_ff);
               rsp_last_in        = list_last;
               if (!list_last) begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff           <= issue_in;
      chk_idx_ff         <= chk_idx_in;
      idx_ff             <= idx_in;
      cmd_ff             <= cmd_in;
      key_ff             <= key_in;
      pend_status_ff     <= pend_status_in;
      pend_pos_ff        <= pend_pos_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_position_ff    <= rsp_position_in;
      rsp_listed_name_ff <= rsp_listed_name_in;
      rsp_last_ff        <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_listed_name = rsp_listed_name_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("Entry count exceeds the table size.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Output register overwritten while a transaction is stalled.");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff) && !(is_full && state_ff == S_IDLE))
      else $error("Write lands outside the occupied part of the table.");

endmodule

`default_nettype wire

// ===== hw/rtl/name_table_insert_delete_search_unit.sv =====
// Name table unit: an unordered table of up to ENTRIES name keys.
// The req_ channel carries one command per transaction (create, delete,
// search, list) with its name key; the rsp_ channel returns results,
// with rsp_last marking the final result of a command. A transaction moves
// on a rising edge where valid is high and stall is low.
// A front stage registers and decodes each command and pushes it into a
// two-entry queue; the back end runs one command at a time against the
// name memory, whose read data is registered.
// Create appends the key unless the table is full. Delete and search read one
// stored entry per cycle until a match or the last entry; delete then moves
// the last entry into the freed slot. List reads, then emits, each entry.
// The queue and front register take up to three more commands meanwhile.
// A stalled result holds in the output register; the back end waits, and
// the front keeps accepting until the queue fills.
// Reset empties the table and the queue; the stored names are not cleared.
`default_nettype none

module name_table_insert_delete_search_unit #(
   parameter int ENTRIES    = ntis_pkg::ENTRIES_DEFAULT,
   parameter int NAME_BYTES = ntis_pkg::NAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ntis_pkg::FUNC_W-1:0]   req_func,
   input  logic [ntis_pkg::NAME_W-1:0]   req_file_name,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ntis_pkg::STATUS_W-1:0] rsp_status,
   output logic [ntis_pkg::POS_W-1:0]    rsp_position,
   output logic [ntis_pkg::NAME_W-1:0]   rsp_listed_name,
   output logic                          rsp_last
);
   import ntis_pkg::*;

   localparam int KW = 8 * NAME_BYTES;
   localparam int QW = KW + FUNC_W;

   logic          push;
   cmd_type       push_cmd;
   logic [KW-1:0] push_key;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   logic [QW-1:0] q_data;

   ntis_front #(
      .NAME_BYTES(NAME_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_file_name (req_file_name),
      .push          (push),
      .push_cmd      (push_cmd),
      .push_key      (push_key),
      .q_full        (q_full)
   );

   ntis_queue #(
      .W(QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_key}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   ntis_back #(
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (cmd_type'(q_data[QW-1:KW])),
      .q_key           (q_data[KW-1:0]),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_listed_name (rsp_listed_name),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
